FILE: hw/rtl/blprd_pkg.sv
// ----------------------------------------------------------------------------
// Long-press detector package
// Shared widths, the reset limit, the per-button event type and the
// lowest-set-bit helper used by the merge stage.
// ----------------------------------------------------------------------------
package blprd_pkg;

   localparam int LEVEL_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int LIMIT_WIDTH = 16;
   localparam int FIRST_WIDTH = 4;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd1000;

   typedef struct packed {
      logic long_hit;
      logic release_hit;
   } lane_event_type;

   function automatic logic [FIRST_WIDTH-1:0] lowest_bit(input logic [LEVEL_WIDTH-1:0] m);
      logic [FIRST_WIDTH-1:0] b;
      b = '0;
      for (int i = LEVEL_WIDTH - 1; i >= 0; i--) begin
         if (m[i]) begin
            b = FIRST_WIDTH'(i);
         end
      end
      return b;
   endfunction

endpackage

FILE: hw/rtl/blprd_lane.sv
// ----------------------------------------------------------------------------
// Long-press detector lane
// Tracks one button: its last level, the time of its press and whether
// the current press has already been reported as long.
// ----------------------------------------------------------------------------
module blprd_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                pressed,
   input  logic [blprd_pkg::TIME_WIDTH-1:0]    time_ms,
   input  logic [blprd_pkg::LIMIT_WIDTH-1:0]   limit,
   output blprd_pkg::lane_event_type           event_out
);

   logic                               prev_pressed_ff;
   logic                               prev_pressed_in;
   logic                               flag_ff;
   logic                               flag_in;
   logic [blprd_pkg::TIME_WIDTH-1:0]   start_ff;
   logic [blprd_pkg::TIME_WIDTH-1:0]   start_in;
   logic [blprd_pkg::TIME_WIDTH-1:0]   held;

   assign held = time_ms - start_ff;

   always_comb begin
      prev_pressed_in       = prev_pressed_ff;
      flag_in               = flag_ff;
      start_in              = start_ff;
      event_out.long_hit    = 1'b0;
      event_out.release_hit = 1'b0;
      if (pressed && !prev_pressed_ff) begin
         start_in = time_ms;
         flag_in  = 1'b0;
      end else if (pressed) begin
         if (held >= {{(blprd_pkg::TIME_WIDTH-blprd_pkg::LIMIT_WIDTH){1'b0}}, limit}
             && !flag_ff) begin
            flag_in            = 1'b1;
            event_out.long_hit = 1'b1;
         end
      end else if (prev_pressed_ff) begin
         event_out.release_hit = !flag_ff;
         flag_in               = 1'b0;
      end
      if (enable) begin
         prev_pressed_in = pressed;
      end else begin
         flag_in  = flag_ff;
         start_in = start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pressed_ff <= 1'b0;
         flag_ff         <= 1'b0;
      end else begin
         prev_pressed_ff <= prev_pressed_in;
         flag_ff         <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule

FILE: hw/rtl/blprd_merge.sv
// ----------------------------------------------------------------------------
// Long-press detector merge stage
// Combines the lane masks into the summary flags and the lowest event bit,
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module blprd_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    long_mask,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    release_mask,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_any_event,
   output logic                                 rsp_long_press_seen,
   output logic                                 rsp_release_seen,
   output logic                                 rsp_first_bit_valid,
   output logic [blprd_pkg::FIRST_WIDTH-1:0]    rsp_first_bit,
   output logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_long_press_mask,
   output logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_release_mask
);

   logic                                valid_ff;
   logic                                valid_in;
   logic                                load;
   logic                                long_any;
   logic                                rel_any;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   pick_mask;
   logic                                any_ff;
   logic                                long_ff;
   logic                                rel_ff;
   logic                                first_valid_ff;
   logic [blprd_pkg::FIRST_WIDTH-1:0]   first_ff;
   logic [blprd_pkg::FIRST_WIDTH-1:0]   first_in;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   long_mask_ff;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   rel_mask_ff;

   assign in_ready  = !valid_ff || rsp_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);
   assign long_any  = |long_mask;
   assign rel_any   = |release_mask;
   assign pick_mask = long_any ? long_mask : release_mask;
   assign first_in  = blprd_pkg::lowest_bit(pick_mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         any_ff         <= long_any || rel_any;
         long_ff        <= long_any;
         rel_ff         <= rel_any;
         first_valid_ff <= long_any || rel_any;
         first_ff       <= first_in;
         long_mask_ff   <= long_mask;
         rel_mask_ff    <= release_mask;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_any_event       = any_ff;
   assign rsp_long_press_seen = long_ff;
   assign rsp_release_seen    = rel_ff;
   assign rsp_first_bit_valid = first_valid_ff;
   assign rsp_first_bit       = first_ff;
   assign rsp_long_press_mask = long_mask_ff;
   assign rsp_release_mask    = rel_mask_ff;

   a_any_matches_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_event == ((rsp_long_press_mask != '0)
                                       || (rsp_release_mask != '0))))
      else $error("any_event disagrees with the masks");

   a_first_bit_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_bit_valid) |->
         (rsp_long_press_seen ? rsp_long_press_mask[rsp_first_bit]
                              : rsp_release_mask[rsp_first_bit]))
      else $error("first_bit does not name an event bit");

   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_first_bit_valid) |-> (rsp_first_bit == '0))
      else $error("first_bit not zero without an event");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first_bit)
                                     && $stable(rsp_long_press_mask)))
      else $error("result changed while stalled");

endmodule

FILE: hw/rtl/button_long_press_release_detector.sv
// A scan's masks are registered in the lane stage, then the merge stage registers the result.
// Throughput: one scan per cycle while req_ready is high; all button lanes update in the transfer cycle.
// The lane stage and the merge stage each hold one item; input stops while both are full and the result is not taken.
// Reset: all buttons released, long-press flags clear, limit 1000 ms; press times
// are loaded on each press and need no reset.
// ----------------------------------------------------------------------------
// Button long-press and release detector
// One lane per button detects presses, long presses and short releases; a
// pipeline register collects the lane masks and the merge stage reports them.
// ----------------------------------------------------------------------------
module button_long_press_release_detector #(
   parameter int BUTTON_COUNT = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    req_button_levels,
   input  logic [blprd_pkg::TIME_WIDTH-1:0]     req_time_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_any_event,
   output logic                                 rsp_long_press_seen,
   output logic                                 rsp_release_seen,
   output logic                                 rsp_first_bit_valid,
   output logic [blprd_pkg::FIRST_WIDTH-1:0]    rsp_first_bit,
   output logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_long_press_mask,
   output logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_release_mask,
   input  logic                                 csr_write_enable,
   input  logic [blprd_pkg::LIMIT_WIDTH-1:0]    csr_write_data
);

   logic [blprd_pkg::LIMIT_WIDTH-1:0]   limit_ff;
   logic                                accept;
   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   logic                                merge_ready;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   long_mask;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   rel_mask;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   long_mask_ff;
   logic [blprd_pkg::LEVEL_WIDTH-1:0]   rel_mask_ff;
   blprd_pkg::lane_event_type           events [BUTTON_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= blprd_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   assign req_ready   = !s1_valid_ff || merge_ready;
   assign accept      = req_valid && req_ready;
   assign s1_valid_in = accept ? 1'b1 : (s1_valid_ff && !merge_ready);

   // Buttons beyond the input lines have no line and read as pressed.
   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic pressed;
      if (i < blprd_pkg::LEVEL_WIDTH) begin : g_line
         assign pressed = ~req_button_levels[i];
      end else begin : g_noline
         assign pressed = 1'b1;
      end
      blprd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .enable    (accept),
         .pressed   (pressed),
         .time_ms   (req_time_ms),
         .limit     (limit_ff),
         .event_out (events[i])
      );
   end

   for (genvar i = 0; i < blprd_pkg::LEVEL_WIDTH; i++) begin : g_mask
      if (i < BUTTON_COUNT) begin : g_used
         assign long_mask[i] = events[i].long_hit;
         assign rel_mask[i]  = events[i].release_hit;
      end else begin : g_unused
         assign long_mask[i] = 1'b0;
         assign rel_mask[i]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         long_mask_ff <= long_mask;
         rel_mask_ff  <= rel_mask;
      end
   end

   blprd_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (s1_valid_ff),
      .in_ready            (merge_ready),
      .long_mask           (long_mask_ff),
      .release_mask        (rel_mask_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_any_event       (rsp_any_event),
      .rsp_long_press_seen (rsp_long_press_seen),
      .rsp_release_seen    (rsp_release_seen),
      .rsp_first_bit_valid (rsp_first_bit_valid),
      .rsp_first_bit       (rsp_first_bit),
      .rsp_long_press_mask (rsp_long_press_mask),
      .rsp_release_mask    (rsp_release_mask)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ((long_mask_ff & rel_mask_ff) == '0))
      else $error("a button both long-pressed and released in one scan");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !merge_ready) |=> (s1_valid_ff && $stable(long_mask_ff)
                                         && $stable(rel_mask_ff)))
      else $error("lane stage changed while the merge stage stalled");

endmodule

FILE: tb/button_event_checker.sv
// ----------------------------------------------------------------------------
// Button event checker
// Watches the scan, result and limit ports of the long-press detector. It keeps
// its own copy of the button state and the limit, computes the expected
// result of every accepted scan, and compares each result transfer field by
// field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module button_event_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    req_button_levels,
   input  logic [blprd_pkg::TIME_WIDTH-1:0]     req_time_ms,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_any_event,
   input  logic                                 rsp_long_press_seen,
   input  logic                                 rsp_release_seen,
   input  logic                                 rsp_first_bit_valid,
   input  logic [blprd_pkg::FIRST_WIDTH-1:0]    rsp_first_bit,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_long_press_mask,
   input  logic [blprd_pkg::LEVEL_WIDTH-1:0]    rsp_release_mask,
   input  logic                                 csr_write_enable,
   input  logic [blprd_pkg::LIMIT_WIDTH-1:0]    csr_write_data,
   output int                                   mismatch_count,
   output int                                   outstanding_count
);

   typedef struct packed {
      logic                              any_event;
      logic                              long_press_seen;
      logic                              release_seen;
      logic                              first_bit_valid;
      logic [blprd_pkg::FIRST_WIDTH-1:0] first_bit;
      logic [blprd_pkg::LEVEL_WIDTH-1:0] long_press_mask;
      logic [blprd_pkg::LEVEL_WIDTH-1:0] release_mask;
   } scan_report_type;

   scan_report_type                   expected_reports[$];
   logic [blprd_pkg::LEVEL_WIDTH-1:0] last_levels;
   logic [blprd_pkg::TIME_WIDTH-1:0]  press_time [blprd_pkg::LEVEL_WIDTH];
   logic                              long_flag [blprd_pkg::LEVEL_WIDTH];
   logic [blprd_pkg::LIMIT_WIDTH-1:0] limit_ms;
   int                                mismatch_total;

   initial begin
      mismatch_total = 0;
      mismatch_count = 0;
      outstanding_count = 0;
   end

   function automatic scan_report_type predict_scan_events(
         input logic [blprd_pkg::LEVEL_WIDTH-1:0] levels,
         input logic [blprd_pkg::TIME_WIDTH-1:0]  now);
      scan_report_type                   r;
      logic [blprd_pkg::TIME_WIDTH-1:0]  held;
      logic [blprd_pkg::LEVEL_WIDTH-1:0] pick;
      logic                              now_down;
      logic                              was_down;
      r = '0;
      for (int b = 0; b < blprd_pkg::LEVEL_WIDTH; b++) begin
         now_down = !levels[b];
         was_down = !last_levels[b];
         if (now_down && !was_down) begin
            press_time[b] = now;
            long_flag[b] = 1'b0;
         end else if (now_down) begin
            held = now - press_time[b];
            if (held >= {{(blprd_pkg::TIME_WIDTH-blprd_pkg::LIMIT_WIDTH){1'b0}}, limit_ms}
                && !long_flag[b]) begin
               long_flag[b] = 1'b1;
               r.long_press_mask[b] = 1'b1;
            end
         end else if (was_down) begin
            if (!long_flag[b]) begin
               r.release_mask[b] = 1'b1;
            end
            long_flag[b] = 1'b0;
         end
      end
      last_levels = levels;
      r.long_press_seen = |r.long_press_mask;
      r.release_seen = |r.release_mask;
      r.any_event = r.long_press_seen | r.release_seen;
      r.first_bit_valid = r.any_event;
      pick = r.long_press_seen ? r.long_press_mask : r.release_mask;
      for (int i = blprd_pkg::LEVEL_WIDTH - 1; i >= 0; i--) begin
         if (pick[i]) begin
            r.first_bit = i[blprd_pkg::FIRST_WIDTH-1:0];
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      scan_report_type want;
      if (reset) begin
         expected_reports.delete();
         last_levels = '1;
         limit_ms = blprd_pkg::LIMIT_RESET;
         for (int b = 0; b < blprd_pkg::LEVEL_WIDTH; b++) begin
            press_time[b] = '0;
            long_flag[b] = 1'b0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result transfer with no scan outstanding");
               mismatch_total++;
            end else begin
               want = expected_reports.pop_front();
               check_field("any_event", 32'(want.any_event), 32'(rsp_any_event));
               check_field("long_press_seen", 32'(want.long_press_seen),
                           32'(rsp_long_press_seen));
               check_field("release_seen", 32'(want.release_seen), 32'(rsp_release_seen));
               check_field("first_bit_valid", 32'(want.first_bit_valid),
                           32'(rsp_first_bit_valid));
               check_field("first_bit", 32'(want.first_bit), 32'(rsp_first_bit));
               check_field("long_press_mask", 32'(want.long_press_mask),
                           32'(rsp_long_press_mask));
               check_field("release_mask", 32'(want.release_mask), 32'(rsp_release_mask));
            end
         end
         if (req_valid && req_ready) begin
            expected_reports.push_back(predict_scan_events(req_button_levels, req_time_ms));
         end
         if (csr_write_enable) begin
            limit_ms = csr_write_data;
         end
      end
      mismatch_count <= mismatch_total;
      outstanding_count <= expected_reports.size();
   end

endmodule

FILE: tb/button_long_press_release_detector_tb.sv
// ----------------------------------------------------------------------------
// Long-press detector testbench
// Drives button scans with a directed opening and phases of random press and
// release sequences under several long-press limits, with bursty scan traffic
// and a stalling result receiver. The checker beside the block predicts and
// compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module button_long_press_release_detector_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 8;
   localparam int PHASE_SCANS = 190;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_HALF,
      RX_SPARSE,
      RX_MOSTLY
   } rx_pattern_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [blprd_pkg::LEVEL_WIDTH-1:0] req_button_levels = '1;
   logic [blprd_pkg::TIME_WIDTH-1:0]  req_time_ms = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_any_event;
   logic                              rsp_long_press_seen;
   logic                              rsp_release_seen;
   logic                              rsp_first_bit_valid;
   logic [blprd_pkg::FIRST_WIDTH-1:0] rsp_first_bit;
   logic [blprd_pkg::LEVEL_WIDTH-1:0] rsp_long_press_mask;
   logic [blprd_pkg::LEVEL_WIDTH-1:0] rsp_release_mask;
   logic                              csr_write_enable = 1'b0;
   logic [blprd_pkg::LIMIT_WIDTH-1:0] csr_write_data = '0;
   int                                mismatch_count;
   int                                outstanding_count;
   int                                burst_left = 0;
   int                                cycle_count;
   rx_pattern_type                    rx_pattern = RX_ALWAYS;
   int                                rx_left = 0;

   always #10 clock = ~clock;

   button_long_press_release_detector u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_button_levels   (req_button_levels),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_any_event       (rsp_any_event),
      .rsp_long_press_seen (rsp_long_press_seen),
      .rsp_release_seen    (rsp_release_seen),
      .rsp_first_bit_valid (rsp_first_bit_valid),
      .rsp_first_bit       (rsp_first_bit),
      .rsp_long_press_mask (rsp_long_press_mask),
      .rsp_release_mask    (rsp_release_mask),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   button_event_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_button_levels   (req_button_levels),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_any_event       (rsp_any_event),
      .rsp_long_press_seen (rsp_long_press_seen),
      .rsp_release_seen    (rsp_release_seen),
      .rsp_first_bit_valid (rsp_first_bit_valid),
      .rsp_first_bit       (rsp_first_bit),
      .rsp_long_press_mask (rsp_long_press_mask),
      .rsp_release_mask    (rsp_release_mask),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .outstanding_count   (outstanding_count)
   );

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(4, 60);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_pattern)
         RX_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RX_HALF: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RX_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   task automatic offer_scan(input logic [blprd_pkg::LEVEL_WIDTH-1:0] levels,
                             input logic [blprd_pkg::TIME_WIDTH-1:0]  stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_button_levels <= levels;
      req_time_ms <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_count != 0);
   endtask

   task automatic write_limit(input logic [blprd_pkg::LIMIT_WIDTH-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("button_long_press_release_detector verification failed");
      $finish;
   end

   initial begin
      logic [blprd_pkg::LEVEL_WIDTH-1:0] levels;
      logic [blprd_pkg::TIME_WIDTH-1:0]  clock_ms;
      logic [blprd_pkg::LIMIT_WIDTH-1:0] phase_limits [PHASES];
      int                                step_max;
      int                                roll;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The opening runs at the reset limit of 1000 ms.
      offer_scan(16'hFFFF, 32'd0);
      offer_scan(16'h0000, 32'd100);
      offer_scan(16'h0000, 32'd1099);
      offer_scan(16'h0000, 32'd1100);
      offer_scan(16'h0000, 32'd5000);
      offer_scan(16'hFFFF, 32'd5100);
      offer_scan(16'h7FFF, 32'd6000);
      offer_scan(16'hFFFF, 32'd6001);
      offer_scan(16'hFDF7, 32'd7000);
      offer_scan(16'hFDF7, 32'd8000);
      offer_scan(16'hFDFD, 32'd8100);
      offer_scan(16'hFDFF, 32'd8200);
      offer_scan(16'hFDEB, 32'd9000);
      // A long press on one button and a lower short release in the same scan.
      offer_scan(16'hFDEF, 32'd10000);
      offer_scan(16'hFFFF, 32'd10001);
      // The held time is taken across the wrap of the millisecond counter.
      offer_scan(16'hFFFE, 32'hFFFF_FF00);
      offer_scan(16'hFFFE, 32'h0000_02E7);
      offer_scan(16'hFFFE, 32'h0000_02E8);
      // A time that steps backwards reads as a very long hold.
      offer_scan(16'hFFDE, 32'h0001_0000);
      offer_scan(16'hFFDE, 32'h0000_F000);
      offer_scan(16'hFFFF, 32'hAAAA_5555);
      offer_scan(16'h5555, 32'h5555_AAAA);
      offer_scan(16'hAAAA, 32'h5555_AAAB);
      offer_scan(16'hFFFF, 32'h5555_AAAC);

      phase_limits[0] = 16'd1;
      phase_limits[1] = 16'd0;
      phase_limits[2] = 16'hFFFF;
      phase_limits[3] = 16'($urandom_range(2, 50));
      phase_limits[4] = 16'($urandom_range(1, 65535));
      phase_limits[5] = 16'($urandom_range(2, 50));
      phase_limits[6] = 16'($urandom_range(1, 65535));
      phase_limits[7] = 16'($urandom_range(51, 2000));

      levels = 16'hFFFF;
      for (int p = 0; p < PHASES; p++) begin
         write_limit(phase_limits[p]);
         step_max = phase_limits[p] / 8 + 1;
         clock_ms = $urandom;
         for (int n = 0; n < PHASE_SCANS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               clock_ms = $urandom;
            end else if (roll < 4) begin
               clock_ms = clock_ms - $urandom_range(1, phase_limits[p] + 1);
            end else begin
               clock_ms = clock_ms + $urandom_range(0, step_max);
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               levels = 16'($urandom);
            end else if (roll < 35) begin
               levels = levels ^ (16'h0001 << $urandom_range(0, 15));
            end else if (roll < 45) begin
               levels = levels ^ (16'h0001 << $urandom_range(0, 15))
                               ^ (16'h0001 << $urandom_range(0, 15));
            end
            offer_scan(levels, clock_ms);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("button_long_press_release_detector verification clean");
      end else begin
         $display("button_long_press_release_detector verification failed");
      end
      $finish;
   end

endmodule
